>>> hdl/c8eu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c8eu_pkg
// Types, operation codes and constants shared by the 8-bit execute unit.
// ----------------------------------------------------------------------------
package c8eu_pkg;

  typedef logic [5:0] mode_t;

  localparam mode_t OP_ADC = 6'd0;
  localparam mode_t OP_SBC = 6'd1;
  localparam mode_t OP_AND = 6'd2;
  localparam mode_t OP_ORA = 6'd3;
  localparam mode_t OP_EOR = 6'd4;
  localparam mode_t OP_CMP = 6'd5;
  localparam mode_t OP_CPX = 6'd6;
  localparam mode_t OP_CPY = 6'd7;
  localparam mode_t OP_BIT = 6'd8;
  localparam mode_t OP_LDA = 6'd9;
  localparam mode_t OP_LDX = 6'd10;
  localparam mode_t OP_LDY = 6'd11;
  localparam mode_t OP_STA = 6'd12;
  localparam mode_t OP_STX = 6'd13;
  localparam mode_t OP_STY = 6'd14;
  localparam mode_t OP_ASL = 6'd15;
  localparam mode_t OP_LSR = 6'd16;
  localparam mode_t OP_ROL = 6'd17;
  localparam mode_t OP_ROR = 6'd18;
  localparam mode_t OP_INC = 6'd19;
  localparam mode_t OP_DEC = 6'd20;
  localparam mode_t OP_INX = 6'd21;
  localparam mode_t OP_INY = 6'd22;
  localparam mode_t OP_DEX = 6'd23;
  localparam mode_t OP_DEY = 6'd24;
  localparam mode_t OP_TAX = 6'd25;
  localparam mode_t OP_TAY = 6'd26;
  localparam mode_t OP_TXA = 6'd27;
  localparam mode_t OP_TYA = 6'd28;
  localparam mode_t OP_TSX = 6'd29;
  localparam mode_t OP_TXS = 6'd30;
  localparam mode_t OP_CLC = 6'd31;
  localparam mode_t OP_CLD = 6'd32;
  localparam mode_t OP_CLI = 6'd33;
  localparam mode_t OP_CLV = 6'd34;
  localparam mode_t OP_SEC = 6'd35;
  localparam mode_t OP_SED = 6'd36;
  localparam mode_t OP_SEI = 6'd37;
  localparam mode_t OP_BCC = 6'd38;
  localparam mode_t OP_BCS = 6'd39;
  localparam mode_t OP_BEQ = 6'd40;
  localparam mode_t OP_BMI = 6'd41;
  localparam mode_t OP_BNE = 6'd42;
  localparam mode_t OP_BPL = 6'd43;
  localparam mode_t OP_BVC = 6'd44;
  localparam mode_t OP_BVS = 6'd45;
  localparam mode_t OP_LAX = 6'd46;
  localparam mode_t OP_SAX = 6'd47;
  localparam mode_t OP_DCP = 6'd48;
  localparam mode_t OP_ISB = 6'd49;
  localparam mode_t OP_SLO = 6'd50;
  localparam mode_t OP_RLA = 6'd51;
  localparam mode_t OP_SRE = 6'd52;
  localparam mode_t OP_RRA = 6'd53;
  localparam mode_t OP_NOP = 6'd54;

  // status bit positions
  localparam int FL_C = 0;
  localparam int FL_Z = 1;
  localparam int FL_I = 2;
  localparam int FL_D = 3;
  localparam int FL_U = 5;
  localparam int FL_V = 6;
  localparam int FL_N = 7;

  // shift kinds
  typedef enum logic [1:0] {
    SH_ASL = 2'd0,
    SH_LSR = 2'd1,
    SH_ROL = 2'd2,
    SH_ROR = 2'd3
  } shift_kind_t;

  typedef struct packed {
    mode_t      mode;
    logic [7:0] operand;
    logic       on_accumulator;
  } in_item_t;

  typedef struct packed {
    logic [7:0] acc_value;
    logic [7:0] x_value;
    logic [7:0] y_value;
    logic [7:0] flags_value;
    logic [7:0] store_data;
    logic       store_enable;
    logic       branch_taken;
  } out_item_t;

  typedef struct packed {
    logic [7:0] a;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] sp;
    logic [7:0] p;
  } arch_t;

  localparam arch_t ARCH_RESET = '{a: 8'h00, x: 8'h00, y: 8'h00, sp: 8'd253, p: 8'd36};

endpackage
`default_nettype wire

>>> hdl/c8eu_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c8eu_alu
// Single-pass datapath: next register file, flags, store and branch result
// for one operation.
// ----------------------------------------------------------------------------
module c8eu_alu (
  input  var c8eu_pkg::in_item_t  item,
  input  var c8eu_pkg::arch_t     cur,
  output c8eu_pkg::arch_t         nxt,
  output c8eu_pkg::out_item_t     res
);
  import c8eu_pkg::*;

  function automatic logic [7:0] set_nz(input logic [7:0] p, input logic [7:0] v);
    logic [7:0] q;
    q        = p;
    q[FL_N]  = v[7];
    q[FL_Z]  = (v == 8'h00);
    return q;
  endfunction

  logic [7:0]  m;
  logic [7:0]  m_inc;
  logic [7:0]  m_dec;
  logic        cin;

  shift_kind_t sh_kind;
  logic [7:0]  sh_in;
  logic [7:0]  sh_out;
  logic        sh_c;

  logic [7:0]  add_b;
  logic        add_cin;
  logic [8:0]  sum;
  logic        add_v;

  logic [7:0]  cmp_reg;
  logic [7:0]  cmp_val;
  logic [8:0]  diff;

  assign m     = item.operand;
  assign m_inc = m + 8'd1;
  assign m_dec = m - 8'd1;
  assign cin   = cur.p[FL_C];

  always_comb begin
    unique case (item.mode)
      OP_LSR, OP_SRE: sh_kind = SH_LSR;
      OP_ROL, OP_RLA: sh_kind = SH_ROL;
      OP_ROR, OP_RRA: sh_kind = SH_ROR;
      default:        sh_kind = SH_ASL;
    endcase
    sh_in = (item.on_accumulator && item.mode >= OP_ASL && item.mode <= OP_ROR) ? cur.a : m;
    unique case (sh_kind)
      SH_ASL: begin
        sh_out = {sh_in[6:0], 1'b0};
        sh_c   = sh_in[7];
      end
      SH_LSR: begin
        sh_out = {1'b0, sh_in[7:1]};
        sh_c   = sh_in[0];
      end
      SH_ROL: begin
        sh_out = {sh_in[6:0], cin};
        sh_c   = sh_in[7];
      end
      default: begin
        sh_out = {cin, sh_in[7:1]};
        sh_c   = sh_in[0];
      end
    endcase
  end

  // shared adder: ADC, SBC, ISB, RRA
  always_comb begin
    unique case (item.mode)
      OP_SBC:  add_b = ~m;
      OP_ISB:  add_b = ~m_inc;
      OP_RRA:  add_b = sh_out;
      default: add_b = m;
    endcase
    add_cin = (item.mode == OP_RRA) ? sh_c : cin;
    sum     = {1'b0, cur.a} + {1'b0, add_b} + {8'h00, add_cin};
    add_v   = ~(cur.a[7] ^ add_b[7]) & (cur.a[7] ^ sum[7]);
  end

  // shared comparator: CMP, CPX, CPY, DCP
  always_comb begin
    unique case (item.mode)
      OP_CPX:  cmp_reg = cur.x;
      OP_CPY:  cmp_reg = cur.y;
      default: cmp_reg = cur.a;
    endcase
    cmp_val = (item.mode == OP_DCP) ? m_dec : m;
    diff    = {1'b0, cmp_reg} - {1'b0, cmp_val};
  end

  always_comb begin
    nxt = cur;
    res = '0;
    unique case (item.mode)
      OP_ADC, OP_SBC: begin
        nxt.a        = sum[7:0];
        nxt.p        = set_nz(cur.p, sum[7:0]);
        nxt.p[FL_C]  = sum[8];
        nxt.p[FL_V]  = add_v;
      end
      OP_AND: begin
        nxt.a = cur.a & m;
        nxt.p = set_nz(cur.p, cur.a & m);
      end
      OP_ORA: begin
        nxt.a = cur.a | m;
        nxt.p = set_nz(cur.p, cur.a | m);
      end
      OP_EOR: begin
        nxt.a = cur.a ^ m;
        nxt.p = set_nz(cur.p, cur.a ^ m);
      end
      OP_CMP, OP_CPX, OP_CPY: begin
        nxt.p       = set_nz(cur.p, diff[7:0]);
        nxt.p[FL_C] = ~diff[8];
      end
      OP_BIT: begin
        nxt.p[FL_Z] = ((cur.a & m) == 8'h00);
        nxt.p[FL_N] = m[7];
        nxt.p[FL_V] = m[6];
      end
      OP_LDA: begin
        nxt.a = m;
        nxt.p = set_nz(cur.p, m);
      end
      OP_LDX: begin
        nxt.x = m;
        nxt.p = set_nz(cur.p, m);
      end
      OP_LDY: begin
        nxt.y = m;
        nxt.p = set_nz(cur.p, m);
      end
      OP_STA: begin
        res.store_data   = cur.a;
        res.store_enable = 1'b1;
      end
      OP_STX: begin
        res.store_data   = cur.x;
        res.store_enable = 1'b1;
      end
      OP_STY: begin
        res.store_data   = cur.y;
        res.store_enable = 1'b1;
      end
      OP_ASL, OP_LSR, OP_ROL, OP_ROR: begin
        nxt.p       = set_nz(cur.p, sh_out);
        nxt.p[FL_C] = sh_c;
        if (item.on_accumulator) begin
          nxt.a = sh_out;
        end else begin
          res.store_data   = sh_out;
          res.store_enable = 1'b1;
        end
      end
      OP_INC: begin
        res.store_data   = m_inc;
        res.store_enable = 1'b1;
        nxt.p            = set_nz(cur.p, m_inc);
      end
      OP_DEC: begin
        res.store_data   = m_dec;
        res.store_enable = 1'b1;
        nxt.p            = set_nz(cur.p, m_dec);
      end
      OP_INX: begin
        nxt.x = cur.x + 8'd1;
        nxt.p = set_nz(cur.p, cur.x + 8'd1);
      end
      OP_INY: begin
        nxt.y = cur.y + 8'd1;
        nxt.p = set_nz(cur.p, cur.y + 8'd1);
      end
      OP_DEX: begin
        nxt.x = cur.x - 8'd1;
        nxt.p = set_nz(cur.p, cur.x - 8'd1);
      end
      OP_DEY: begin
        nxt.y = cur.y - 8'd1;
        nxt.p = set_nz(cur.p, cur.y - 8'd1);
      end
      OP_TAX: begin
        nxt.x = cur.a;
        nxt.p = set_nz(cur.p, cur.a);
      end
      OP_TAY: begin
        nxt.y = cur.a;
        nxt.p = set_nz(cur.p, cur.a);
      end
      OP_TXA: begin
        nxt.a = cur.x;
        nxt.p = set_nz(cur.p, cur.x);
      end
      OP_TYA: begin
        nxt.a = cur.y;
        nxt.p = set_nz(cur.p, cur.y);
      end
      OP_TSX: begin
        nxt.x = cur.sp;
        nxt.p = set_nz(cur.p, cur.sp);
      end
      OP_TXS: nxt.sp = cur.x;
      OP_CLC: nxt.p[FL_C] = 1'b0;
      OP_CLD: nxt.p[FL_D] = 1'b0;
      OP_CLI: nxt.p[FL_I] = 1'b0;
      OP_CLV: nxt.p[FL_V] = 1'b0;
      OP_SEC: nxt.p[FL_C] = 1'b1;
      OP_SED: nxt.p[FL_D] = 1'b1;
      OP_SEI: nxt.p[FL_I] = 1'b1;
      OP_BCC: res.branch_taken = ~cur.p[FL_C];
      OP_BCS: res.branch_taken = cur.p[FL_C];
      OP_BEQ: res.branch_taken = cur.p[FL_Z];
      OP_BMI: res.branch_taken = cur.p[FL_N];
      OP_BNE: res.branch_taken = ~cur.p[FL_Z];
      OP_BPL: res.branch_taken = ~cur.p[FL_N];
      OP_BVC: res.branch_taken = ~cur.p[FL_V];
      OP_BVS: res.branch_taken = cur.p[FL_V];
      OP_LAX: begin
        nxt.a = m;
        nxt.x = m;
        nxt.p = set_nz(cur.p, m);
      end
      OP_SAX: begin
        res.store_data   = cur.a & cur.x;
        res.store_enable = 1'b1;
      end
      OP_DCP: begin
        res.store_data   = m_dec;
        res.store_enable = 1'b1;
        nxt.p            = set_nz(cur.p, diff[7:0]);
        nxt.p[FL_C]      = ~diff[8];
      end
      OP_ISB: begin
        res.store_data   = m_inc;
        res.store_enable = 1'b1;
        nxt.a            = sum[7:0];
        nxt.p            = set_nz(cur.p, sum[7:0]);
        nxt.p[FL_C]      = sum[8];
        nxt.p[FL_V]      = add_v;
      end
      OP_SLO: begin
        res.store_data   = sh_out;
        res.store_enable = 1'b1;
        nxt.a            = cur.a | sh_out;
        nxt.p            = set_nz(cur.p, cur.a | sh_out);
        nxt.p[FL_C]      = sh_c;
      end
      OP_RLA: begin
        res.store_data   = sh_out;
        res.store_enable = 1'b1;
        nxt.a            = cur.a & sh_out;
        nxt.p            = set_nz(cur.p, cur.a & sh_out);
        nxt.p[FL_C]      = sh_c;
      end
      OP_SRE: begin
        res.store_data   = sh_out;
        res.store_enable = 1'b1;
        nxt.a            = cur.a ^ sh_out;
        nxt.p            = set_nz(cur.p, cur.a ^ sh_out);
        nxt.p[FL_C]      = sh_c;
      end
      OP_RRA: begin
        res.store_data   = sh_out;
        res.store_enable = 1'b1;
        nxt.a            = sum[7:0];
        nxt.p            = set_nz(cur.p, sum[7:0]);
        nxt.p[FL_C]      = sum[8];
        nxt.p[FL_V]      = add_v;
      end
      default: ;
    endcase
    nxt.p[FL_U]     = 1'b1;
    res.acc_value   = nxt.a;
    res.x_value     = nxt.x;
    res.y_value     = nxt.y;
    res.flags_value = nxt.p;
  end

endmodule
`default_nettype wire

>>> hdl/cpu_8bit_execute_unit_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpu_8bit_execute_unit_core
// Execute stage of an 8-bit accumulator CPU: A, X, Y, SP and status.
//
//   channel  | handshake              | payload
//   ---------+------------------------+----------------------------
//   input    | in_valid / in_ready    | in_item  (mode, operand, acc)
//   output   | out_valid / out_ready  | out_item (regs, flags, store)
//
// One item per cycle sustained while out_ready stays high; an accepted item
// goes into the input register, then through the datapath into the result register.
// Register file updates when the item moves into the result register.
// Reset: A, X, Y = 0, SP = 253, P = 36; both stages empty.
// Output stall holds the result and the input register; in_ready falls
// only when both are full and out_ready is low.
// ----------------------------------------------------------------------------
module cpu_8bit_execute_unit_core (
  input  var logic                 clk,
  input  var logic                 rst,
  input  var logic                 in_valid,
  output logic                     in_ready,
  input  var c8eu_pkg::in_item_t   in_item,
  output logic                     out_valid,
  input  var logic                 out_ready,
  output c8eu_pkg::out_item_t      out_item
);
  import c8eu_pkg::*;

  logic      s1_valid;
  in_item_t  s1_item;
  arch_t     st;
  arch_t     st_next;
  out_item_t res;
  logic      advance;

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  c8eu_alu u_alu (
    .item (s1_item),
    .cur  (st),
    .nxt  (st_next),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      st        <= ARCH_RESET;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (!out_valid || out_ready) begin
        out_valid <= s1_valid;
      end
      if (advance) begin
        st <= st_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item <= in_item;
    end
    if (advance) begin
      out_item <= res;
    end
  end

  a_unused_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_item.flags_value[FL_U])
    else $error("unused status bit clear on result");

  a_store_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_item.store_enable) |-> (out_item.store_data == 8'h00))
    else $error("store data nonzero without store");

  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(st))
    else $error("register file changed without an item");

  a_result_matches_state: assert property (@(posedge clk) disable iff (rst)
    advance |=> (out_item.acc_value == st.a && out_item.x_value == st.x &&
                 out_item.y_value == st.y && out_item.flags_value == st.p))
    else $error("result registers differ from register file");

  a_no_loss: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !advance) |=> s1_valid)
    else $error("pending item dropped");

endmodule
`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for cpu_8bit_execute_unit_core. A directed table walks
// the operation groups and edge cases, then random instructions run under
// three handshake pressure profiles. An in-bench model of A, X, Y, SP and the
// status byte predicts every result item, which is checked field by field.
// ----------------------------------------------------------------------------
module testbench;
  import c8eu_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int RANDOM_ITEMS = 500;

  typedef struct {
    in_item_t  stim;
    bit        known;
    out_item_t want;
  } op_row_t;

  logic      clk;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  arch_t     cpu;
  out_item_t due_results[$];
  op_row_t   directed_rows[$];
  int        errors = 0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  int        quiet_cycles = 0;

  cpu_8bit_execute_unit_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---- predictor ----
  function automatic void set_nz(logic [7:0] v);
    cpu.p[FL_N] = v[7];
    cpu.p[FL_Z] = (v == 8'h00);
  endfunction

  function automatic void add_with_carry(logic [7:0] m);
    logic [8:0] sum;
    logic [7:0] r;
    sum = {1'b0, cpu.a} + {1'b0, m} + {8'h00, cpu.p[FL_C]};
    r = sum[7:0];
    cpu.p[FL_C] = sum[8];
    cpu.p[FL_V] = ~(cpu.a[7] ^ m[7]) & (cpu.a[7] ^ r[7]);
    cpu.a = r;
    set_nz(r);
  endfunction

  function automatic void compare_reg(logic [7:0] r, logic [7:0] m);
    cpu.p[FL_C] = (r >= m);
    set_nz(r - m);
  endfunction

  function automatic logic [7:0] shift_byte(shift_kind_t kind, logic [7:0] v);
    logic [7:0] r;
    case (kind)
      SH_ASL: r = {v[6:0], 1'b0};
      SH_LSR: r = {1'b0, v[7:1]};
      SH_ROL: r = {v[6:0], cpu.p[FL_C]};
      default: r = {cpu.p[FL_C], v[7:1]};
    endcase
    cpu.p[FL_C] = (kind == SH_ASL || kind == SH_ROL) ? v[7] : v[0];
    set_nz(r);
    return r;
  endfunction

  function automatic out_item_t execute_op(in_item_t it);
    out_item_t  res;
    logic [7:0] m;
    logic [7:0] t;
    logic [7:0] sdata;
    logic [5:0] delta;
    logic       sen;
    logic       taken;
    m = it.operand;
    sdata = 8'h00;
    sen = 1'b0;
    taken = 1'b0;
    case (it.mode)
      OP_ADC: add_with_carry(m);
      OP_SBC: add_with_carry(~m);
      OP_AND: begin cpu.a = cpu.a & m; set_nz(cpu.a); end
      OP_ORA: begin cpu.a = cpu.a | m; set_nz(cpu.a); end
      OP_EOR: begin cpu.a = cpu.a ^ m; set_nz(cpu.a); end
      OP_CMP: compare_reg(cpu.a, m);
      OP_CPX: compare_reg(cpu.x, m);
      OP_CPY: compare_reg(cpu.y, m);
      OP_BIT: begin
        cpu.p[FL_Z] = ((cpu.a & m) == 8'h00);
        cpu.p[FL_N] = m[7];
        cpu.p[FL_V] = m[6];
      end
      OP_LDA: begin cpu.a = m; set_nz(m); end
      OP_LDX: begin cpu.x = m; set_nz(m); end
      OP_LDY: begin cpu.y = m; set_nz(m); end
      OP_STA: begin sdata = cpu.a; sen = 1'b1; end
      OP_STX: begin sdata = cpu.x; sen = 1'b1; end
      OP_STY: begin sdata = cpu.y; sen = 1'b1; end
      OP_ASL, OP_LSR, OP_ROL, OP_ROR: begin
        delta = it.mode - OP_ASL;
        if (it.on_accumulator) begin
          cpu.a = shift_byte(shift_kind_t'(delta[1:0]), cpu.a);
        end else begin
          sdata = shift_byte(shift_kind_t'(delta[1:0]), m);
          sen = 1'b1;
        end
      end
      OP_INC: begin sdata = m + 8'd1; sen = 1'b1; set_nz(sdata); end
      OP_DEC: begin sdata = m - 8'd1; sen = 1'b1; set_nz(sdata); end
      OP_INX: begin cpu.x = cpu.x + 8'd1; set_nz(cpu.x); end
      OP_INY: begin cpu.y = cpu.y + 8'd1; set_nz(cpu.y); end
      OP_DEX: begin cpu.x = cpu.x - 8'd1; set_nz(cpu.x); end
      OP_DEY: begin cpu.y = cpu.y - 8'd1; set_nz(cpu.y); end
      OP_TAX: begin cpu.x = cpu.a; set_nz(cpu.x); end
      OP_TAY: begin cpu.y = cpu.a; set_nz(cpu.y); end
      OP_TXA: begin cpu.a = cpu.x; set_nz(cpu.a); end
      OP_TYA: begin cpu.a = cpu.y; set_nz(cpu.a); end
      OP_TSX: begin cpu.x = cpu.sp; set_nz(cpu.x); end
      OP_TXS: cpu.sp = cpu.x;
      OP_CLC: cpu.p[FL_C] = 1'b0;
      OP_CLD: cpu.p[FL_D] = 1'b0;
      OP_CLI: cpu.p[FL_I] = 1'b0;
      OP_CLV: cpu.p[FL_V] = 1'b0;
      OP_SEC: cpu.p[FL_C] = 1'b1;
      OP_SED: cpu.p[FL_D] = 1'b1;
      OP_SEI: cpu.p[FL_I] = 1'b1;
      OP_BCC: taken = ~cpu.p[FL_C];
      OP_BCS: taken = cpu.p[FL_C];
      OP_BEQ: taken = cpu.p[FL_Z];
      OP_BMI: taken = cpu.p[FL_N];
      OP_BNE: taken = ~cpu.p[FL_Z];
      OP_BPL: taken = ~cpu.p[FL_N];
      OP_BVC: taken = ~cpu.p[FL_V];
      OP_BVS: taken = cpu.p[FL_V];
      OP_LAX: begin cpu.a = m; cpu.x = m; set_nz(m); end
      OP_SAX: begin sdata = cpu.a & cpu.x; sen = 1'b1; end
      OP_DCP: begin
        t = m - 8'd1; sdata = t; sen = 1'b1;
        compare_reg(cpu.a, t);
      end
      OP_ISB: begin
        t = m + 8'd1; sdata = t; sen = 1'b1;
        add_with_carry(~t);
      end
      OP_SLO: begin
        t = shift_byte(SH_ASL, m); sdata = t; sen = 1'b1;
        cpu.a = cpu.a | t; set_nz(cpu.a);
      end
      OP_RLA: begin
        t = shift_byte(SH_ROL, m); sdata = t; sen = 1'b1;
        cpu.a = cpu.a & t; set_nz(cpu.a);
      end
      OP_SRE: begin
        t = shift_byte(SH_LSR, m); sdata = t; sen = 1'b1;
        cpu.a = cpu.a ^ t; set_nz(cpu.a);
      end
      OP_RRA: begin
        t = shift_byte(SH_ROR, m); sdata = t; sen = 1'b1;
        add_with_carry(t);
      end
      default: ;
    endcase
    cpu.p[FL_U] = 1'b1;
    res.acc_value    = cpu.a;
    res.x_value      = cpu.x;
    res.y_value      = cpu.y;
    res.flags_value  = cpu.p;
    res.store_data   = sen ? sdata : 8'h00;
    res.store_enable = sen;
    res.branch_taken = taken;
    return res;
  endfunction

  // ---- stimulus helpers ----
  task automatic row(mode_t md, logic [7:0] op, logic on_acc);
    op_row_t r;
    r.stim = '{mode: md, operand: op, on_accumulator: on_acc};
    r.known = 1'b0;
    r.want = '0;
    directed_rows.push_back(r);
  endtask

  task automatic row_known(mode_t md, logic [7:0] op, logic on_acc, out_item_t want);
    op_row_t r;
    r.stim = '{mode: md, operand: op, on_accumulator: on_acc};
    r.known = 1'b1;
    r.want = want;
    directed_rows.push_back(r);
  endtask

  function automatic in_item_t random_instr();
    in_item_t   it;
    logic [7:0] edges [6];
    edges = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'hFE, 8'hFF};
    if ($urandom_range(9) == 0)
      it.mode = mode_t'($urandom_range(63, 55));
    else
      it.mode = mode_t'($urandom_range(54, 0));
    if ($urandom_range(3) == 0)
      it.operand = edges[$urandom_range(5)];
    else
      it.operand = 8'($urandom_range(255));
    it.on_accumulator = 1'($urandom_range(1));
    return it;
  endfunction

  // Holds valid until the item is taken; returns in the step it was accepted.
  task automatic send_instr(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
  endtask

  // ---- result check ----
  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t mismatch %s expected %02h actual %02h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        $display("%0t unexpected result item %h", $time, out_item);
        errors++;
      end else begin
        want = due_results.pop_front();
        check_field("acc_value", want.acc_value, out_item.acc_value);
        check_field("x_value", want.x_value, out_item.x_value);
        check_field("y_value", want.y_value, out_item.y_value);
        check_field("flags_value", want.flags_value, out_item.flags_value);
        check_field("store_data", want.store_data, out_item.store_data);
        check_field("store_enable", {7'd0, want.store_enable}, {7'd0, out_item.store_enable});
        check_field("branch_taken", {7'd0, want.branch_taken}, {7'd0, out_item.branch_taken});
      end
    end
  end

  always @(posedge clk) begin
    if (rst)
      out_ready <= 1'b0;
    else
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t watchdog: no progress", $time);
      $display("cpu_8bit_execute_unit_core test failed");
      $finish;
    end
  end

  // ---- main sequence ----
  initial begin
    out_item_t got;
    int        phase;
    int        n;
    cpu = ARCH_RESET;

    // reset state, then loads hitting N and Z, stores and a taken branch
    row_known(OP_NOP, 8'h00, 1'b0, '{8'h00, 8'h00, 8'h00, 8'h24, 8'h00, 1'b0, 1'b0});
    row_known(OP_LDA, 8'h80, 1'b1, '{8'h80, 8'h00, 8'h00, 8'hA4, 8'h00, 1'b0, 1'b0});
    row_known(OP_LDX, 8'hFF, 1'b0, '{8'h80, 8'hFF, 8'h00, 8'hA4, 8'h00, 1'b0, 1'b0});
    row_known(OP_LDY, 8'h00, 1'b0, '{8'h80, 8'hFF, 8'h00, 8'h26, 8'h00, 1'b0, 1'b0});
    row_known(OP_STA, 8'h00, 1'b0, '{8'h80, 8'hFF, 8'h00, 8'h26, 8'h80, 1'b1, 1'b0});
    row_known(OP_STX, 8'hFF, 1'b1, '{8'h80, 8'hFF, 8'h00, 8'h26, 8'hFF, 1'b1, 1'b0});
    row_known(OP_BEQ, 8'hFF, 1'b0, '{8'h80, 8'hFF, 8'h00, 8'h26, 8'h00, 1'b0, 1'b1});
    row_known(OP_LDA, 8'h7F, 1'b0, '{8'h7F, 8'hFF, 8'h00, 8'h24, 8'h00, 1'b0, 1'b0});
    row(OP_ADC, 8'h01, 1'b0);
    row(OP_SED, 8'h00, 1'b0);
    row(OP_SBC, 8'hFF, 1'b0);
    row(OP_ADC, 8'hFF, 1'b0);
    row(OP_CMP, 8'h00, 1'b0);
    row(OP_CPX, 8'hFF, 1'b0);
    row(OP_CPY, 8'h80, 1'b0);
    row(OP_BIT, 8'hC0, 1'b0);
    row(OP_ASL, 8'h00, 1'b1);
    row(OP_ROR, 8'h01, 1'b0);
    row(OP_ROL, 8'h80, 1'b1);
    row(OP_LSR, 8'hFF, 1'b0);
    row(OP_INC, 8'hFF, 1'b0);
    row(OP_DEC, 8'h00, 1'b0);
    row(OP_TSX, 8'h00, 1'b0);
    row(OP_DEX, 8'h00, 1'b0);
    row(OP_TXS, 8'h00, 1'b0);
    row(OP_ISB, 8'hFF, 1'b1);
    row(OP_RRA, 8'h01, 1'b1);
    row(OP_DCP, 8'h00, 1'b0);
    row(OP_SAX, 8'h00, 1'b0);
    row(6'd63, 8'hFF, 1'b1);

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_instr(directed_rows[i].stim);
      got = execute_op(directed_rows[i].stim);
      due_results.push_back(directed_rows[i].known ? directed_rows[i].want : got);
    end
    drain_results();

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 21; recv_idle_pct = 66; end
        1: begin send_idle_pct = 66; recv_idle_pct = 21; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (n = 0; n < RANDOM_ITEMS / 3; n++) begin
        in_item_t it;
        it = random_instr();
        send_instr(it);
        due_results.push_back(execute_op(it));
      end
      drain_results();
    end

    repeat (8) @(posedge clk);
    if (errors == 0)
      $display("cpu_8bit_execute_unit_core test passed");
    else
      $display("cpu_8bit_execute_unit_core test failed");
    $finish;
  end

endmodule
